// ===== hw/rtl/flnc_pkg.sv =====
// ----------------------------------------------------------------------------
// flnc_pkg: shared types and constants for the four-list neighbor census
// List capacity, field widths, queue sizing and the transfer record that
// travels from the front end to the merge engine.
// ----------------------------------------------------------------------------
package flnc_pkg;

  // list capacity and element width
  localparam int MAX_DEGREE  = 256;
  localparam int ACTOR_BITS  = 16;
  localparam int LIST_COUNT  = 4;
  localparam int SEL_BITS    = $clog2(LIST_COUNT);
  localparam int ADDR_BITS   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LEN_BITS    = $clog2(MAX_DEGREE + 1);

  // result counters
  localparam int COUNT_BITS  = 9;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int HIT_BITS    = $clog2(LIST_COUNT + 1);
  localparam logic [HIT_BITS-1:0] MATCH_THREE = HIT_BITS'(3);
  localparam logic [HIT_BITS-1:0] MATCH_FOUR  = HIT_BITS'(4);
  localparam logic [HIT_BITS-1:0] MIN_LIVE    = HIT_BITS'(3);

  // queue between front end and merge engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SEL_BITS-1:0]   list_sel_t;
  typedef logic [ACTOR_BITS-1:0] actor_t;

  // one queued operation: optional append, optional census launch
  typedef struct packed {
    list_sel_t sel;
    actor_t    neighbor;
    logic      has;
    logic      census;
  } op_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/flnc_queue.sv =====
// ----------------------------------------------------------------------------
// flnc_queue: short operation queue
// Small FIFO that decouples item intake from list storage and the merge.
// ----------------------------------------------------------------------------
module flnc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  flnc_pkg::op_t   push_op,
  input  logic            pop,
  output flnc_pkg::op_t   pop_op,
  output flnc_pkg::q_stat_t stat
);
  import flnc_pkg::*;

  op_t                  entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] fill;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (fill == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_op     = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (do_push && !do_pop) fill <= fill + QCNT_BITS'(1);
      else if (do_pop && !do_push) fill <= fill - QCNT_BITS'(1);
    end
  end

endmodule

// ===== hw/rtl/flnc_front.sv =====
// ----------------------------------------------------------------------------
// flnc_front: item intake and classification
// Tracks which lists are closed, drops items for closed lists, queues
// appends, and marks the item that closes the fourth list as a census.
// ----------------------------------------------------------------------------
module flnc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  flnc_pkg::list_sel_t list_select,
  input  flnc_pkg::actor_t   neighbor,
  input  logic               has_neighbor,
  input  logic               last,
  input  flnc_pkg::q_stat_t  q_stat,
  input  logic               census_done,
  output logic               push,
  output flnc_pkg::op_t      push_op
);
  import flnc_pkg::*;

  logic [LIST_COUNT-1:0] closed;
  logic [LIST_COUNT-1:0] closed_next;
  logic                  waiting;
  logic                  accept;
  logic                  live_item;
  logic                  all_closed;

  assign busy   = q_stat.full || waiting;
  assign accept = start && !busy;

  // classify the incoming item
  always_comb begin
    live_item   = !closed[list_select];
    closed_next = closed;
    if (last || !has_neighbor) closed_next[list_select] = 1'b1;
    all_closed  = &closed_next;
  end

  assign push             = accept && live_item && (has_neighbor || all_closed);
  assign push_op.sel      = list_select;
  assign push_op.neighbor = neighbor;
  assign push_op.has      = has_neighbor;
  assign push_op.census   = all_closed;

  // closed bits and census hold-off
  always_ff @(posedge clk) begin
    if (rst) begin
      closed  <= '0;
      waiting <= 1'b0;
    end else if (census_done) begin
      closed  <= '0;
      waiting <= 1'b0;
    end else if (accept && live_item) begin
      closed <= closed_next;
      if (all_closed) waiting <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/flnc_back.sv =====
// ----------------------------------------------------------------------------
// flnc_back: list storage and multiway merge engine
// Appends queued elements into four list banks and walks them with one head
// per list (bank read, then compare and advance per step), reporting counts.
// ----------------------------------------------------------------------------
module flnc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  flnc_pkg::q_stat_t                q_stat,
  input  flnc_pkg::op_t                    pop_op,
  output logic                             pop,
  output logic                             done,
  output logic [flnc_pkg::COUNT_BITS-1:0]  three_count,
  output logic [flnc_pkg::COUNT_BITS-1:0]  four_count,
  output logic                             overflow
);
  import flnc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_STEP
  } state_t;

  state_t                state;
  actor_t                banks [LIST_COUNT][MAX_DEGREE];
  actor_t                heads [LIST_COUNT];
  logic [LEN_BITS-1:0]   lengths [LIST_COUNT];
  logic [LEN_BITS-1:0]   pos [LIST_COUNT];
  logic                  ovf_flag;
  logic [COUNT_BITS-1:0] n3;
  logic [COUNT_BITS-1:0] n4;

  logic                  wr_en;
  logic [LIST_COUNT-1:0] live;
  logic [LIST_COUNT-1:0] match;
  logic [HIT_BITS-1:0]   live_cnt;
  logic [HIT_BITS-1:0]   hits;
  logic [ACTOR_BITS:0]   key [LIST_COUNT];
  logic [ACTOR_BITS:0]   min01;
  logic [ACTOR_BITS:0]   min23;
  logic [ACTOR_BITS:0]   min_all;

  assign pop   = (state == S_IDLE) && !q_stat.empty;
  assign wr_en = pop && pop_op.has && (lengths[pop_op.sel] < LEN_BITS'(MAX_DEGREE));

  // list banks: one write per cycle while idle, one registered read per bank
  always_ff @(posedge clk) begin
    for (int b = 0; b < LIST_COUNT; b++) begin
      if (wr_en && (pop_op.sel == SEL_BITS'(b))) begin
        banks[b][lengths[b][ADDR_BITS-1:0]] <= pop_op.neighbor;
      end
      heads[b] <= banks[b][pos[b][ADDR_BITS-1:0]];
    end
  end

  // merge step: smallest live head and the lists that hold it
  always_comb begin
    live_cnt = '0;
    for (int k = 0; k < LIST_COUNT; k++) begin
      live[k]  = pos[k] < lengths[k];
      live_cnt = live_cnt + HIT_BITS'(live[k]);
      key[k]   = {!live[k], heads[k]};
    end
    min01   = (key[0] < key[1]) ? key[0] : key[1];
    min23   = (key[2] < key[3]) ? key[2] : key[3];
    min_all = (min01 < min23) ? min01 : min23;
    hits    = '0;
    for (int k = 0; k < LIST_COUNT; k++) begin
      match[k] = live[k] && (heads[k] == min_all[ACTOR_BITS-1:0]);
      hits     = hits + HIT_BITS'(match[k]);
    end
  end

  // sequencer, list bookkeeping and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ovf_flag <= 1'b0;
      done     <= 1'b0;
      for (int k = 0; k < LIST_COUNT; k++) lengths[k] <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (pop_op.has) begin
              if (wr_en) begin
                lengths[pop_op.sel] <= lengths[pop_op.sel] + LEN_BITS'(1);
              end else begin
                ovf_flag <= 1'b1;
              end
            end
            if (pop_op.census) begin
              for (int k = 0; k < LIST_COUNT; k++) pos[k] <= '0;
              n3    <= '0;
              n4    <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          // heads are being read; finish once fewer than three lists remain
          if (live_cnt < MIN_LIVE) begin
            done        <= 1'b1;
            three_count <= n3;
            four_count  <= n4;
            overflow    <= ovf_flag;
            ovf_flag    <= 1'b0;
            for (int k = 0; k < LIST_COUNT; k++) lengths[k] <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          for (int k = 0; k < LIST_COUNT; k++) begin
            if (match[k]) pos[k] <= pos[k] + LEN_BITS'(1);
          end
          if (hits == MATCH_THREE && n3 != COUNT_MAX) n3 <= n3 + COUNT_BITS'(1);
          if (hits == MATCH_FOUR && n4 != COUNT_MAX) n4 <= n4 + COUNT_BITS'(1);
          state <= S_FETCH;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/four_list_neighbor_census.sv =====
// ----------------------------------------------------------------------------
// four_list_neighbor_census: neighbor census over four sorted lists
// Loads four neighbor lists and counts neighbors shared by three or four.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive list_select, neighbor, has_neighbor and last with start;
//   an item transfers on a clock edge with start high and busy low. Items
//   for a list that is already closed are dropped. Elements beyond the
//   list capacity are dropped and reported through overflow.
//   Loading: one item per cycle while the four-entry queue has room; the
//   bank write port drains it at one element per cycle while no merge runs.
//   Census: the item that closes the fourth list starts the merge. Each
//   merge step is a bank read, then a compare and advance; the merge takes
//   at most as many steps as there are stored elements. busy stays high
//   until the result is out.
//   Output: done is high for exactly one cycle with three_count, four_count
//   and overflow valid; the receiver cannot stall and must take it then.
//   Afterwards lengths, closed lists and overflow are cleared for the next
//   census.
//   Reset: synchronous rst empties the queue and clears all list state; the
//   list banks need no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module four_list_neighbor_census (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  list_select,
  input  logic [15:0] neighbor,
  input  logic        has_neighbor,
  input  logic        last,
  output logic        done,
  output logic [8:0]  three_count,
  output logic [8:0]  four_count,
  output logic        overflow
);
  import flnc_pkg::*;

  q_stat_t q_stat;
  op_t     push_op;
  op_t     pop_op;
  logic    push;
  logic    pop;

  flnc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .list_select  (list_select),
    .neighbor     (neighbor[ACTOR_BITS-1:0]),
    .has_neighbor (has_neighbor),
    .last         (last),
    .q_stat       (q_stat),
    .census_done  (done),
    .push         (push),
    .push_op      (push_op)
  );

  flnc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .stat    (q_stat)
  );

  flnc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .pop_op      (pop_op),
    .pop         (pop),
    .done        (done),
    .three_count (three_count),
    .four_count  (four_count),
    .overflow    (overflow)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for four_list_neighbor_census
// Loads neighbor lists through the start/busy port and checks every census
// result (three_count, four_count, overflow) against a local model of the
// list store and the multiway merge, or against counts typed into a short
// table of directed items, which comes first. Random censuses follow, with
// overlapping sorted lists, a few noisy lists and one list run past capacity.
// ----------------------------------------------------------------------------
module tb_top;
  import flnc_pkg::*;

  localparam int ITEM_TARGET = 650;
  localparam int IDLE_LIMIT  = 8 * LIST_COUNT * MAX_DEGREE + 4000;
  localparam int DRAIN_CYCLES = 50;

  // one census result
  typedef struct packed {
    logic [COUNT_BITS-1:0] threes;
    logic [COUNT_BITS-1:0] fours;
    logic                  ovf;
  } census_t;

  // one row of the directed table
  typedef struct packed {
    list_sel_t             sel;
    actor_t                nb;
    logic                  has;
    logic                  fin;
    logic                  chk;
    logic [COUNT_BITS-1:0] t3;
    logic [COUNT_BITS-1:0] t4;
    logic                  ov;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  list_select;
  logic [15:0] neighbor;
  logic        has_neighbor;
  logic        last;
  logic        done;
  logic [8:0]  three_count;
  logic [8:0]  four_count;
  logic        overflow;

  // typed-in expectation that travels with a directed item
  logic        typed_on;
  census_t     typed_res;

  // local copy of the list state
  actor_t      bank_model [LIST_COUNT][MAX_DEGREE];
  int unsigned fill_model [LIST_COUNT];
  logic        shut_model [LIST_COUNT];
  logic        spill_model;

  census_t     pending_census [$];
  int          mismatches;
  int          idle_cycles;
  int          items_sent;
  logic        burst;

  // stimulus planning
  actor_t      pool [$];
  actor_t      plan_q [LIST_COUNT][$];
  logic [3:0]  open_lists;
  logic [3:0]  close_empty;
  dir_row_t    dir_rows [0:23];

  four_list_neighbor_census dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .list_select  (list_select),
    .neighbor     (neighbor),
    .has_neighbor (has_neighbor),
    .last         (last),
    .done         (done),
    .three_count  (three_count),
    .four_count   (four_count),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // multiway merge over the stored lists
  function automatic census_t count_shared();
    int unsigned pos [LIST_COUNT];
    int unsigned smallest;
    int          live;
    int          hits;
    census_t     res;
    live = 0;
    res  = '0;
    for (int k = 0; k < LIST_COUNT; k++) begin
      pos[k] = 0;
      if (fill_model[k] > 0) live++;
    end
    while (live >= int'(MATCH_THREE)) begin
      smallest = 32'hFFFF_FFFF;
      hits = 0;
      for (int k = 0; k < LIST_COUNT; k++)
        if (pos[k] < fill_model[k] && bank_model[k][pos[k]] < smallest)
          smallest = bank_model[k][pos[k]];
      for (int k = 0; k < LIST_COUNT; k++) begin
        if (pos[k] < fill_model[k] && bank_model[k][pos[k]] == smallest) begin
          hits++;
          pos[k]++;
          if (pos[k] >= fill_model[k]) live--;
        end
      end
      if (hits == int'(MATCH_THREE)) begin
        if (res.threes != COUNT_MAX) res.threes++;
      end else if (hits == int'(MATCH_FOUR)) begin
        if (res.fours != COUNT_MAX) res.fours++;
      end
    end
    res.ovf = spill_model;
    return res;
  endfunction

  // apply one transferred item; returns 1 when it completes a census
  function automatic bit load_list_item(input list_sel_t s, input actor_t v,
                                        input logic h, input logic f,
                                        output census_t res);
    bit all_shut;
    res = '0;
    if (shut_model[s]) return 1'b0;
    if (h) begin
      if (fill_model[s] < MAX_DEGREE) begin
        bank_model[s][fill_model[s]] = v;
        fill_model[s]++;
      end else begin
        spill_model = 1'b1;
      end
    end
    if (f || !h) shut_model[s] = 1'b1;
    all_shut = 1'b1;
    for (int k = 0; k < LIST_COUNT; k++)
      if (!shut_model[k]) all_shut = 1'b0;
    if (!all_shut) return 1'b0;
    res = count_shared();
    for (int k = 0; k < LIST_COUNT; k++) begin
      fill_model[k] = 0;
      shut_model[k] = 1'b0;
    end
    spill_model = 1'b0;
    return 1'b1;
  endfunction

  // monitor: predict on input transfers, check result strobes, watchdog
  always @(posedge clk) begin
    census_t got;
    census_t want;
    bit      moved;
    if (!rst) begin
      moved = 1'b0;
      if (done) begin
        moved = 1'b1;
        if (pending_census.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected result three=%0d four=%0d ovf=%0d",
                     three_count, four_count, overflow);
        end else begin
          want = pending_census.pop_front();
          if (three_count !== want.threes || four_count !== want.fours ||
              overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected three=%0d four=%0d ovf=%0d, got %0d %0d %0d",
                       want.threes, want.fours, want.ovf,
                       three_count, four_count, overflow);
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        if (load_list_item(list_select, neighbor, has_neighbor, last, got))
          pending_census.push_back(typed_on ? typed_res : got);
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles", idle_cycles);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // drive one item and hold it until it transfers
  task automatic xfer(input list_sel_t s, input actor_t v, input logic h,
                      input logic f, input logic chk, input census_t want);
    start        <= 1'b1;
    list_select  <= s;
    neighbor     <= v;
    has_neighbor <= h;
    last         <= f;
    typed_on     <= chk;
    typed_res    <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random gap after a transfer: mostly none, some short, a few long
  task automatic pause_sender();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (burst || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender off until every pending census has reported
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_census.size() != 0) @(posedge clk);
  endtask

  // one random census: plan four lists from a shared pool, then send them
  // interleaved, with stray items for lists already closed
  task automatic run_census_sequence(input bit big);
    int      n;
    int      mode;
    int      pos;
    int      k;
    int      p;
    int      total;
    bit      dup;
    actor_t  v;
    actor_t  tmp;
    logic    f;
    pool.delete();
    for (int i = 0; i < LIST_COUNT; i++) plan_q[i].delete();
    burst = ($urandom_range(0, 3) == 0);
    p = $urandom_range(0, LIST_COUNT - 1);
    if (big) begin
      // strictly ascending, a few entries past capacity
      total = MAX_DEGREE + $urandom_range(1, 3);
      for (int j = 0; j < total; j++)
        pool.push_back(actor_t'(j * 250 + $urandom_range(0, 249)));
    end else begin
      n = $urandom_range(1, 10);
      mode = $urandom_range(0, 2);
      for (int j = 0; j < n; j++) begin
        case (mode)
          0: v = actor_t'($urandom_range(0, 31));
          1: v = actor_t'($urandom_range(0, 65535));
          default: begin
            if (j == 0) v = '0;
            else if (j == 1) v = '1;
            else v = actor_t'($urandom_range(0, 65535));
          end
        endcase
        // sorted insert, no duplicates
        pos = 0;
        dup = 1'b0;
        foreach (pool[q]) begin
          if (pool[q] == v) dup = 1'b1;
          if (pool[q] < v) pos = q + 1;
        end
        if (!dup) pool.insert(pos, v);
      end
    end
    for (int i = 0; i < LIST_COUNT; i++) begin
      if (big && i == p) begin
        plan_q[i] = pool;
      end else begin
        foreach (pool[q])
          if ($urandom_range(0, 9) < (big ? 1 : 7)) plan_q[i].push_back(pool[q]);
      end
      // occasional broken ordering or duplicate
      if (!big && $urandom_range(0, 7) == 0) begin
        if (plan_q[i].size() >= 2) begin
          tmp = plan_q[i][0];
          plan_q[i][0] = plan_q[i][1];
          plan_q[i][1] = tmp;
        end else if (plan_q[i].size() == 1) begin
          plan_q[i].push_back(plan_q[i][0]);
        end
      end
      close_empty[i] = (plan_q[i].size() == 0) ||
                       (!(big && i == p) && $urandom_range(0, 3) == 0);
    end
    open_lists = 4'hF;
    while (open_lists != 4'h0) begin
      if (open_lists != 4'hF && $urandom_range(0, 11) == 0) begin
        // stray item for a closed list, dropped by the block
        do k = $urandom_range(0, LIST_COUNT - 1); while (open_lists[k]);
        xfer(list_sel_t'(k), actor_t'($urandom_range(0, 65535)),
             logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        do k = $urandom_range(0, LIST_COUNT - 1); while (!open_lists[k]);
        if (plan_q[k].size() > 0) begin
          v = plan_q[k].pop_front();
          f = (plan_q[k].size() == 0) && !close_empty[k];
          xfer(list_sel_t'(k), v, 1'b1, f, 1'b0, '0);
          if (f) open_lists[k] = 1'b0;
        end else begin
          xfer(list_sel_t'(k), actor_t'($urandom_range(0, 65535)), 1'b0,
               logic'($urandom_range(0, 1)), 1'b0, '0);
          open_lists[k] = 1'b0;
        end
        items_sent++;
      end
      pause_sender();
    end
  endtask

  // stimulus
  initial begin
    census_t want;
    int      census_no;
    rst          = 1'b1;
    start        = 1'b0;
    list_select  = '0;
    neighbor     = '0;
    has_neighbor = 1'b0;
    last         = 1'b0;
    typed_on     = 1'b0;
    typed_res    = '0;
    burst        = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    items_sent   = 0;
    spill_model  = 1'b0;
    for (int k = 0; k < LIST_COUNT; k++) begin
      fill_model[k] = 0;
      shut_model[k] = 1'b0;
    end

    // sel, neighbor, has, last, typed check, three, four, overflow
    dir_rows = '{
      // all lists closed empty, one stray item on a closed list
      '{2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd1, 16'h1234, 1'b0, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd2, 16'h0000, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd3, 16'hFFFF, 1'b0, 1'b1, 1'b1, 9'd0, 9'd0, 1'b0},
      // extremes shared by all four lists
      '{2'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd1, 16'h0000, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd2, 16'h0000, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd2, 16'hFFFF, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd3, 16'h0000, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd3, 16'hFFFF, 1'b1, 1'b1, 1'b1, 9'd0, 9'd2, 1'b0},
      // three-way match; last list closed by an empty item
      '{2'd3, 16'h0007, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd0, 16'h0005, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd1, 16'h0005, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd2, 16'h0005, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd3, 16'hAAAA, 1'b0, 1'b0, 1'b1, 9'd1, 9'd0, 1'b0},
      // unsorted and duplicate entries
      '{2'd0, 16'h0009, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd0, 16'h0003, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd1, 16'h0003, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd1, 16'h0003, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd2, 16'h0003, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      '{2'd3, 16'h0009, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      want.threes = dir_rows[i].t3;
      want.fours  = dir_rows[i].t4;
      want.ovf    = dir_rows[i].ov;
      xfer(dir_rows[i].sel, dir_rows[i].nb, dir_rows[i].has, dir_rows[i].fin,
           dir_rows[i].chk, want);
      pause_sender();
    end
    wait_for_results();

    // random censuses; one runs a list past capacity
    census_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_census_sequence(census_no == 3);
      census_no++;
      if (census_no % 5 == 0) wait_for_results();
    end

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (pending_census.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_census.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
